>>> hdl/ucs_pkg.sv
// Shared types and constants for the endpoint-0 control transfer sequencer.
// Used by ucs_step and usb_control_endpoint_sequencer; depends on nothing.

package ucs_pkg;

    // Field widths of one event beat and one result beat
    localparam int LEN_W      = 9;
    localparam int WLEN_W     = 16;
    localparam int RX_W       = 7;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;

    // Endpoint-0 event kinds
    typedef enum logic [1:0] {
        EV_SETUP     = 2'd0,
        EV_IN_SENT   = 2'd1,
        EV_OUT_RCVD  = 2'd2,
        EV_BUS_RESET = 2'd3
    } t_event;

    // Control transfer stages; code 7 is unused and treated as stall
    typedef enum logic [2:0] {
        ST_STALL         = 3'd0,
        ST_DATA_IN       = 3'd1,
        ST_LAST_DATA_IN  = 3'd2,
        ST_DATA_OUT      = 3'd3,
        ST_LAST_DATA_OUT = 3'd4,
        ST_STATUS_IN     = 3'd5,
        ST_STATUS_OUT    = 3'd6
    } t_stage;

    typedef struct packed {
        t_event              req_type;
        logic                setup_ok;
        logic                dir_in;
        logic                request_error;
        logic [LEN_W-1:0]    reply_length;
        logic [WLEN_W-1:0]   requested_length;
        logic [RX_W-1:0]     rx_length;
    } t_item;

    typedef struct packed {
        t_stage              stage;
        logic [LEN_W-1:0]    in_remaining;
        logic [LEN_W-1:0]    in_offset;
        logic [WLEN_W-1:0]   out_remaining;
        logic [LEN_W-1:0]    out_offset;
        logic                zero_packet_due;
    } t_state;

    typedef struct packed {
        t_stage              stage;
        logic                send_packet;
        logic [RX_W-1:0]     send_length;
        logic [LEN_W-1:0]    send_offset;
        logic [LEN_W-1:0]    rx_offset;
        logic                run_set_request;
        logic                reset_handlers;
    } t_result;

endpackage

>>> hdl/ucs_step.sv
// Next-state and result logic for one endpoint-0 event.
// Purely combinational; depends on ucs_pkg.

module ucs_step #(
    parameter int MAX_PACKET  = 64,
    parameter int REPLY_BYTES = 256
) (
    input  ucs_pkg::t_state  i_state,
    input  ucs_pkg::t_item   i_item,
    output ucs_pkg::t_state  o_state,
    output ucs_pkg::t_result o_result
);

    localparam int               NMULT     = 512 / MAX_PACKET;
    localparam logic [16:0]      REPLY_LIM = 17'(REPLY_BYTES);
    localparam logic [15:0]      MAXP16    = 16'(MAX_PACKET);
    localparam logic [8:0]       MAXP9     = 9'(MAX_PACKET);
    localparam logic [6:0]       MAXP7     = 7'(MAX_PACKET);

    logic [16:0] rlen17;
    logic [16:0] wlen17;
    logic [16:0] len_a;
    logic [16:0] len17;
    logic [8:0]  len;
    logic        len_is_mult;
    logic        setup_zpd;

    logic [8:0]  sn_rem;
    logic [8:0]  sn_off;
    logic        sn_zpd;
    logic [8:0]  sn_n;
    logic [8:0]  sn_rem_new;
    logic [8:0]  sn_off_new;
    logic        sn_last;

    logic [15:0] out_rem_new;
    logic [8:0]  out_off_new;

    // Clip the reply to the buffer and to wLength
    always_comb begin
        rlen17 = {8'b0, i_item.reply_length};
        wlen17 = {1'b0, i_item.requested_length};
        len_a  = (rlen17 > REPLY_LIM) ? REPLY_LIM : rlen17;
        len17  = (len_a > wlen17) ? wlen17 : len_a;
        len    = len17[8:0];
    end

    // Flag a clipped length that is a whole number of packets
    always_comb begin
        len_is_mult = 1'b0;
        for (int k = 0; k < NMULT; k++) begin
            if (len == 9'(k * MAX_PACKET)) begin
                len_is_mult = 1'b1;
            end
        end
        setup_zpd = (len17 < wlen17) && len_is_mult;
    end

    // Size the next IN packet, from setup values or from stored counts
    always_comb begin
        if (i_item.req_type == ucs_pkg::EV_SETUP) begin
            sn_rem = len;
            sn_off = '0;
            sn_zpd = setup_zpd;
        end else begin
            sn_rem = i_state.in_remaining;
            sn_off = i_state.in_offset;
            sn_zpd = i_state.zero_packet_due;
        end
        sn_n       = (sn_rem < MAXP9) ? sn_rem : MAXP9;
        sn_rem_new = sn_rem - sn_n;
        sn_off_new = sn_off + sn_n;
        sn_last    = (sn_n < MAXP9) || ((sn_rem_new == '0) && !sn_zpd);
    end

    // Advance the OUT counts by the received beat
    always_comb begin
        out_rem_new = i_state.out_remaining - {9'b0, i_item.rx_length};
        out_off_new = i_state.out_offset + {2'b0, i_item.rx_length};
    end

    // Stage machine: next state and result
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_item.req_type)
            ucs_pkg::EV_SETUP: begin
                if (!i_item.setup_ok || i_item.request_error) begin
                    o_state.stage = ucs_pkg::ST_STALL;
                end else if (i_item.dir_in) begin
                    o_state.zero_packet_due = setup_zpd;
                    o_state.in_remaining    = sn_rem_new;
                    o_state.in_offset       = sn_off_new;
                    o_result.send_packet    = 1'b1;
                    o_result.send_length    = sn_n[6:0];
                    o_result.send_offset    = sn_off;
                    o_state.stage = sn_last ? ucs_pkg::ST_LAST_DATA_IN
                                            : ucs_pkg::ST_DATA_IN;
                end else if (i_item.requested_length != '0) begin
                    if (wlen17 > REPLY_LIM) begin
                        o_state.stage = ucs_pkg::ST_STALL;
                    end else begin
                        o_state.out_offset    = '0;
                        o_state.out_remaining = i_item.requested_length;
                        o_state.stage = (i_item.requested_length <= MAXP16)
                                      ? ucs_pkg::ST_LAST_DATA_OUT
                                      : ucs_pkg::ST_DATA_OUT;
                    end
                end else begin
                    // no data stage: zero-length status packet at once
                    o_result.send_packet = 1'b1;
                    o_state.stage        = ucs_pkg::ST_STATUS_IN;
                end
            end
            ucs_pkg::EV_IN_SENT: begin
                case (i_state.stage)
                    ucs_pkg::ST_DATA_IN: begin
                        o_state.in_remaining = sn_rem_new;
                        o_state.in_offset    = sn_off_new;
                        o_result.send_packet = 1'b1;
                        o_result.send_length = sn_n[6:0];
                        o_result.send_offset = sn_off;
                        o_state.stage = sn_last ? ucs_pkg::ST_LAST_DATA_IN
                                                : ucs_pkg::ST_DATA_IN;
                    end
                    ucs_pkg::ST_LAST_DATA_IN: begin
                        o_state.stage = ucs_pkg::ST_STATUS_OUT;
                    end
                    ucs_pkg::ST_STATUS_IN: begin
                        o_result.run_set_request = 1'b1;
                        o_state.stage            = ucs_pkg::ST_STALL;
                    end
                    default: begin
                        o_state.stage = ucs_pkg::ST_STALL;
                    end
                endcase
            end
            ucs_pkg::EV_OUT_RCVD: begin
                case (i_state.stage)
                    ucs_pkg::ST_DATA_OUT: begin
                        o_result.rx_offset = i_state.out_offset;
                        if (i_item.rx_length != MAXP7) begin
                            o_state.stage = ucs_pkg::ST_STALL;
                        end else begin
                            o_state.out_offset    = out_off_new;
                            o_state.out_remaining = out_rem_new;
                            o_state.stage = (out_rem_new <= MAXP16)
                                          ? ucs_pkg::ST_LAST_DATA_OUT
                                          : ucs_pkg::ST_DATA_OUT;
                        end
                    end
                    ucs_pkg::ST_LAST_DATA_OUT: begin
                        o_result.rx_offset = i_state.out_offset;
                        if ({9'b0, i_item.rx_length} != i_state.out_remaining) begin
                            o_state.stage = ucs_pkg::ST_STALL;
                        end else begin
                            o_result.send_packet = 1'b1;
                            o_state.stage        = ucs_pkg::ST_STATUS_IN;
                        end
                    end
                    default: begin
                        o_state.stage = ucs_pkg::ST_STALL;
                    end
                endcase
            end
            ucs_pkg::EV_BUS_RESET: begin
                o_state.stage           = ucs_pkg::ST_STALL;
                o_state.in_remaining    = '0;
                o_state.in_offset       = '0;
                o_state.out_remaining   = '0;
                o_state.out_offset      = '0;
                o_state.zero_packet_due = 1'b0;
                o_result.reset_handlers = 1'b1;
            end
        endcase
        o_result.stage = o_state.stage;
    end

endmodule

>>> hdl/usb_control_endpoint_sequencer.sv
// Top level of the endpoint-0 control transfer sequencer: event register,
// stage/count state, result register. Depends on ucs_pkg and ucs_step.
//
//   channel   dir  carries                              accepted when
//   s_*       in   one endpoint-0 event (tuser = kind)  i_s_tvalid & o_s_tready
//   m_*       out  stage, IN packet, OUT offset, pulses o_m_tvalid & i_m_tready
//
// An event is registered on accept and resolved once the result register
// can take it: the stage logic updates the state and loads the result
// register. One event per cycle is sustained while the receiver takes every
// result. A stalled result holds in its register while one more event waits
// in the input register. Reset (synchronous, active low) empties both
// registers and returns to stall.

module usb_control_endpoint_sequencer #(
    parameter int MAX_PACKET  = 64,
    parameter int REPLY_BYTES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [0] setup_ok, [1] dir_in, [2] request_error, [11:3] reply_length,
    // [27:12] requested_length, [34:28] rx_length, [39:35] zero
    input  logic [ucs_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [1:0] req_type
    input  logic [ucs_pkg::S_TUSER_W-1:0]    i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [2:0] stage, [3] send_packet, [10:4] send_length, [19:11] send_offset,
    // [28:20] rx_offset, [29] run_set_request, [30] reset_handlers, [31] zero
    output logic [ucs_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    logic             r_in_valid;
    ucs_pkg::t_item   r_item;
    ucs_pkg::t_item   n_item;
    ucs_pkg::t_state  r_state;
    ucs_pkg::t_state  n_state;
    logic             r_out_valid;
    ucs_pkg::t_result r_result;
    ucs_pkg::t_result n_result;
    logic             advance;

    // Unpack the incoming beat
    always_comb begin
        n_item.req_type         = ucs_pkg::t_event'(i_s_tuser[1:0]);
        n_item.setup_ok         = i_s_tdata[0];
        n_item.dir_in           = i_s_tdata[1];
        n_item.request_error    = i_s_tdata[2];
        n_item.reply_length     = i_s_tdata[11:3];
        n_item.requested_length = i_s_tdata[27:12];
        n_item.rx_length        = i_s_tdata[34:28];
    end

    // Resolve the held event when the result register can take it
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    ucs_step #(
        .MAX_PACKET  (MAX_PACKET),
        .REPLY_BYTES (REPLY_BYTES)
    ) u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Control: valid flags and stage/count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: event and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else if (o_s_tready && i_s_tvalid) begin
            r_item <= n_item;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    // Pack the result beat
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0,
                         r_result.reset_handlers,
                         r_result.run_set_request,
                         r_result.rx_offset,
                         r_result.send_offset,
                         r_result.send_length,
                         r_result.send_packet,
                         r_result.stage};

    // A bus reset event leaves all counts cleared
    a_bus_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_item.req_type == ucs_pkg::EV_BUS_RESET) |=> (r_state == '0))
        else $error("bus reset did not clear sequencer state");

    // The last OUT packet always has between one and a full packet left
    a_last_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.stage == ucs_pkg::ST_LAST_DATA_OUT) |->
            (r_state.out_remaining != '0) &&
            (r_state.out_remaining <= 16'(MAX_PACKET)))
        else $error("last_data_out with bad remaining count");

    // In data_out more than a full packet is still owed
    a_data_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.stage == ucs_pkg::ST_DATA_OUT) |->
            (r_state.out_remaining > 16'(MAX_PACKET)))
        else $error("data_out with too few bytes remaining");

    // A full event register behind a stalled result blocks new beats
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("event accepted while both registers are stalled");

    // A SET request runs only on leaving status_in
    a_run_set_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.run_set_request |->
            (r_state.stage == ucs_pkg::ST_STATUS_IN))
        else $error("run_set_request outside status_in");

endmodule

>>> dv/usb_control_endpoint_sequencer_test.sv
// Self-checking testbench for the endpoint-0 control transfer sequencer.
// Drives setup, IN, OUT and bus-reset beats with random gaps and checks every result beat
// against a predictor kept here. Depends on ucs_pkg and usb_control_endpoint_sequencer.

module usb_control_endpoint_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PACKET   = 64;
    localparam int REPLY_BYTES  = 256;
    localparam int N_ITEMS      = 1900;
    localparam int HOLD_AFTER   = 600;      // result count that starts the long receiver hold
    localparam int LONG_HOLD    = 320;      // cycles of that hold
    localparam int TAIL_CYCLES  = 8;
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef struct {
        ucs_pkg::t_item beat;
        bit             wait_empty;    // hold this beat until all results are back
        int unsigned    gap;           // idle cycles before offering it
    } t_backlog_entry;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [ucs_pkg::S_TDATA_W-1:0] i_s_tdata = '0;
    logic [ucs_pkg::S_TUSER_W-1:0] i_s_tuser = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [ucs_pkg::M_TDATA_W-1:0] o_m_tdata;

    t_backlog_entry   event_backlog[$];
    ucs_pkg::t_result results_due[$];

    // Predicted sequencer state
    ucs_pkg::t_stage cur_stage = ucs_pkg::ST_STALL;
    logic [8:0]      in_left = '0;
    logic [8:0]      in_pos = '0;
    logic [15:0]     out_left = '0;
    logic [8:0]      out_pos = '0;
    logic            zlp_owed = 1'b0;

    // Bookkeeping
    int n_accepted = 0;
    int n_results = 0;
    int n_fail = 0;
    int n_queued = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_resets = 0;
    int n_noise = 0;
    int n_stalls_seen = 0;
    int n_set_pulses = 0;
    bit sender_quiet = 1'b0;

    usb_control_endpoint_sequencer #(
        .MAX_PACKET  (MAX_PACKET),
        .REPLY_BYTES (REPLY_BYTES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Size the next IN data packet from what is left of the reply
    function automatic void send_in_packet(inout ucs_pkg::t_result r);
        logic [8:0] n;
        n = (in_left < MAX_PACKET) ? in_left : 9'(MAX_PACKET);
        r.send_packet = 1'b1;
        r.send_length = n[6:0];
        r.send_offset = in_pos;
        in_pos = in_pos + n;
        in_left = in_left - n;
        if (n < MAX_PACKET || (in_left == 0 && !zlp_owed))
            cur_stage = ucs_pkg::ST_LAST_DATA_IN;
        else
            cur_stage = ucs_pkg::ST_DATA_IN;
    endfunction

    // Advance the predicted stage machine by one event and return its result beat
    function automatic ucs_pkg::t_result advance_stage(input ucs_pkg::t_item ev);
        ucs_pkg::t_result r;
        int unsigned      n_len;
        r = '0;
        case (ev.req_type)
            ucs_pkg::EV_SETUP: begin
                if (!ev.setup_ok || ev.request_error) begin
                    cur_stage = ucs_pkg::ST_STALL;
                end else if (ev.dir_in) begin
                    n_len = ev.reply_length;
                    if (n_len > REPLY_BYTES) n_len = REPLY_BYTES;
                    if (n_len > ev.requested_length) n_len = ev.requested_length;
                    zlp_owed = (n_len < ev.requested_length) && (n_len % MAX_PACKET == 0);
                    in_left = n_len[8:0];
                    in_pos = '0;
                    send_in_packet(r);
                end else if (ev.requested_length != 0) begin
                    if (ev.requested_length > REPLY_BYTES) begin
                        cur_stage = ucs_pkg::ST_STALL;
                    end else begin
                        out_pos = '0;
                        out_left = ev.requested_length;
                        cur_stage = (ev.requested_length <= MAX_PACKET) ?
                                    ucs_pkg::ST_LAST_DATA_OUT : ucs_pkg::ST_DATA_OUT;
                    end
                end else begin
                    // no data stage: zero-length status packet right away
                    r.send_packet = 1'b1;
                    cur_stage = ucs_pkg::ST_STATUS_IN;
                end
            end
            ucs_pkg::EV_IN_SENT: begin
                case (cur_stage)
                    ucs_pkg::ST_DATA_IN:      send_in_packet(r);
                    ucs_pkg::ST_LAST_DATA_IN: cur_stage = ucs_pkg::ST_STATUS_OUT;
                    ucs_pkg::ST_STATUS_IN: begin
                        r.run_set_request = 1'b1;
                        cur_stage = ucs_pkg::ST_STALL;
                    end
                    default:                  cur_stage = ucs_pkg::ST_STALL;
                endcase
            end
            ucs_pkg::EV_OUT_RCVD: begin
                case (cur_stage)
                    ucs_pkg::ST_DATA_OUT: begin
                        r.rx_offset = out_pos;
                        if (ev.rx_length != MAX_PACKET) begin
                            cur_stage = ucs_pkg::ST_STALL;
                        end else begin
                            out_pos = out_pos + ev.rx_length;
                            out_left = out_left - ev.rx_length;
                            cur_stage = (out_left <= MAX_PACKET) ?
                                        ucs_pkg::ST_LAST_DATA_OUT : ucs_pkg::ST_DATA_OUT;
                        end
                    end
                    ucs_pkg::ST_LAST_DATA_OUT: begin
                        r.rx_offset = out_pos;
                        if (ev.rx_length != out_left) begin
                            cur_stage = ucs_pkg::ST_STALL;
                        end else begin
                            r.send_packet = 1'b1;
                            cur_stage = ucs_pkg::ST_STATUS_IN;
                        end
                    end
                    default: cur_stage = ucs_pkg::ST_STALL;
                endcase
            end
            default: begin
                cur_stage = ucs_pkg::ST_STALL;
                in_left = '0;
                in_pos = '0;
                out_left = '0;
                out_pos = '0;
                zlp_owed = 1'b0;
                r.reset_handlers = 1'b1;
            end
        endcase
        r.stage = cur_stage;
        return r;
    endfunction

    // Event with every field random; callers overwrite what matters
    function automatic ucs_pkg::t_item make_beat(input ucs_pkg::t_event kind);
        ucs_pkg::t_item b;
        b.req_type = kind;
        b.setup_ok = 1'($urandom_range(0, 1));
        b.dir_in = 1'($urandom_range(0, 1));
        b.request_error = 1'($urandom_range(0, 1));
        b.reply_length = 9'($urandom_range(0, 511));
        b.requested_length = 16'($urandom_range(0, 65535));
        b.rx_length = 7'($urandom_range(0, 127));
        return b;
    endfunction

    task automatic queue_beat(input ucs_pkg::t_item b, input bit wait_empty);
        t_backlog_entry e;
        e.beat = b;
        e.wait_empty = wait_empty;
        e.gap = sender_quiet ? 0 : $urandom_range(0, 11);
        event_backlog.push_back(e);
        n_queued++;
        // switch between gapped and back-to-back stretches
        if (n_queued % 120 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
    endtask

    // Control read: setup, one IN-sent per packet (tweak breaks the count), status OUT
    task automatic queue_read(input int unsigned rlen, input int unsigned wlen,
                              input bit wait_empty, input int tweak);
        ucs_pkg::t_item b;
        int unsigned    n_len;
        int unsigned    n_pkt;
        bit             zlp;
        b = make_beat(ucs_pkg::EV_SETUP);
        b.setup_ok = 1'b1;
        b.dir_in = 1'b1;
        b.request_error = 1'b0;
        b.reply_length = 9'(rlen);
        b.requested_length = 16'(wlen);
        queue_beat(b, wait_empty);
        n_len = (rlen > REPLY_BYTES) ? REPLY_BYTES : rlen;
        if (n_len > wlen) n_len = wlen;
        zlp = (n_len < wlen) && (n_len % MAX_PACKET == 0);
        n_pkt = n_len / MAX_PACKET +
                ((n_len % MAX_PACKET != 0 || zlp || n_len == 0) ? 1 : 0);
        repeat (int'(n_pkt) + tweak) queue_beat(make_beat(ucs_pkg::EV_IN_SENT), 1'b0);
        queue_beat(make_beat(ucs_pkg::EV_OUT_RCVD), 1'b0);
        n_reads++;
    endtask

    // Control write: setup, OUT data beats, status IN.
    // corrupt 1: wrong last remainder, corrupt 2: oversized first beat
    task automatic queue_write(input int unsigned wlen, input bit wait_empty,
                               input int corrupt);
        ucs_pkg::t_item b;
        int unsigned    left;
        int unsigned    take;
        bit             first;
        b = make_beat(ucs_pkg::EV_SETUP);
        b.setup_ok = 1'b1;
        b.dir_in = 1'b0;
        b.request_error = 1'b0;
        b.requested_length = 16'(wlen);
        queue_beat(b, wait_empty);
        left = (wlen > REPLY_BYTES) ? MAX_PACKET : wlen;
        first = 1'b1;
        while (left != 0) begin
            take = (left > MAX_PACKET) ? MAX_PACKET : left;
            b = make_beat(ucs_pkg::EV_OUT_RCVD);
            b.rx_length = 7'(take);
            if (corrupt == 2 && first) b.rx_length = 7'h7F;
            if (corrupt == 1 && take == left)
                b.rx_length = 7'(take + 1 + $urandom_range(0, 60));
            queue_beat(b, 1'b0);
            left -= take;
            first = 1'b0;
        end
        queue_beat(make_beat(ucs_pkg::EV_IN_SENT), 1'b0);
        n_writes++;
    endtask

    function automatic int unsigned pick_reply_length();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return MAX_PACKET * $urandom_range(0, 4);
            2:       return $urandom_range(1, MAX_PACKET - 1);
            3:       return $urandom_range(0, REPLY_BYTES);
            4:       return $urandom_range(REPLY_BYTES + 1, 511);
            default: return MAX_PACKET * $urandom_range(1, 4) + $urandom_range(0, 2) - 1;
        endcase
    endfunction

    function automatic int unsigned pick_read_wlen(input int unsigned rlen);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return rlen;
            2:       return $urandom_range(0, 300);
            3:       return MAX_PACKET * $urandom_range(1, 5);
            4:       return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int unsigned pick_write_wlen();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return $urandom_range(1, MAX_PACKET);
            2:       return $urandom_range(MAX_PACKET + 1, REPLY_BYTES);
            3:       return MAX_PACKET * $urandom_range(1, 4);
            4:       return REPLY_BYTES + 1;
            5:       return $urandom_range(REPLY_BYTES + 1, 65535);
            default: return $urandom_range(1, REPLY_BYTES);
        endcase
    endfunction

    // Driver: offer backlog beats with their gaps, predict on every accepted beat
    t_backlog_entry cur_entry;
    bit             loaded = 1'b0;
    bit             offering = 1'b0;
    int unsigned    gap_left = 0;

    always @(posedge i_clk) begin : event_driver
        int accepted_now;
        if (!i_rst_n) begin
            loaded = 1'b0;
            offering = 1'b0;
            gap_left = 0;
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
            i_s_tuser <= '0;
        end else begin
            accepted_now = n_accepted;
            if (i_s_tvalid && o_s_tready) begin
                results_due.push_back(advance_stage(cur_entry.beat));
                accepted_now = n_accepted + 1;
                n_accepted <= accepted_now;
                loaded = 1'b0;
                offering = 1'b0;
            end
            // pull the next beat, pausing where it asks for a drained block
            if (!loaded && event_backlog.size() != 0) begin
                if (!event_backlog[0].wait_empty || n_results == accepted_now) begin
                    cur_entry = event_backlog.pop_front();
                    gap_left = cur_entry.gap;
                    loaded = 1'b1;
                end
            end
            if (loaded && !offering) begin
                if (gap_left == 0) offering = 1'b1;
                else gap_left--;
            end
            i_s_tvalid <= offering;
            i_s_tdata <= {5'd0, cur_entry.beat.rx_length, cur_entry.beat.requested_length,
                          cur_entry.beat.reply_length, cur_entry.beat.request_error,
                          cur_entry.beat.dir_in, cur_entry.beat.setup_ok};
            i_s_tuser <= cur_entry.beat.req_type;
        end
    end

    // Monitor: check result beats and pace tready
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          receiver_quiet = 1'b0;

    always @(posedge i_clk) begin : result_monitor
        ucs_pkg::t_result got;
        ucs_pkg::t_result want;
        if (!i_rst_n) begin
            stall_left = 0;
            hold_left = 0;
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.stage = ucs_pkg::t_stage'(o_m_tdata[2:0]);
                got.send_packet = o_m_tdata[3];
                got.send_length = o_m_tdata[10:4];
                got.send_offset = o_m_tdata[19:11];
                got.rx_offset = o_m_tdata[28:20];
                got.run_set_request = o_m_tdata[29];
                got.reset_handlers = o_m_tdata[30];
                if (got.stage == ucs_pkg::ST_STALL) n_stalls_seen++;
                if (got.run_set_request) n_set_pulses++;
                if (results_due.size() == 0) begin
                    $error("result beat with none expected: tdata %h", o_m_tdata);
                    n_fail++;
                end else begin
                    want = results_due.pop_front();
                    if (got.stage != want.stage) begin
                        $error("stage: expected %0d, got %0d", want.stage, got.stage);
                        n_fail++;
                    end
                    if (got.send_packet != want.send_packet) begin
                        $error("send_packet: expected %0d, got %0d",
                               want.send_packet, got.send_packet);
                        n_fail++;
                    end
                    if (got.send_length != want.send_length) begin
                        $error("send_length: expected %0d, got %0d",
                               want.send_length, got.send_length);
                        n_fail++;
                    end
                    if (got.send_offset != want.send_offset) begin
                        $error("send_offset: expected %0d, got %0d",
                               want.send_offset, got.send_offset);
                        n_fail++;
                    end
                    if (got.rx_offset != want.rx_offset) begin
                        $error("rx_offset: expected %0d, got %0d",
                               want.rx_offset, got.rx_offset);
                        n_fail++;
                    end
                    if (got.run_set_request != want.run_set_request) begin
                        $error("run_set_request: expected %0d, got %0d",
                               want.run_set_request, got.run_set_request);
                        n_fail++;
                    end
                    if (got.reset_handlers != want.reset_handlers) begin
                        $error("reset_handlers: expected %0d, got %0d",
                               want.reset_handlers, got.reset_handlers);
                        n_fail++;
                    end
                end
                n_results <= n_results + 1;
                // one long hold so the block backs up into its input
                if (!hold_done && n_results + 1 >= HOLD_AFTER) begin
                    hold_left = LONG_HOLD;
                    hold_done = 1'b1;
                end
                if ((n_results + 1) % 128 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
                stall_left = receiver_quiet ? 0 : $urandom_range(0, 11);
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        ucs_pkg::t_item b;
        int unsigned    pick;
        int unsigned    rlen;
        bit             drain;
        int             tweak;

        // Directed: reset, events out of place, bad setups
        queue_beat(make_beat(ucs_pkg::EV_BUS_RESET), 1'b0);
        n_resets++;
        queue_beat(make_beat(ucs_pkg::EV_IN_SENT), 1'b0);
        b = make_beat(ucs_pkg::EV_SETUP);
        b.setup_ok = 1'b0;
        b.dir_in = 1'b1;
        b.reply_length = 9'(REPLY_BYTES);
        b.requested_length = 16'hFFFF;
        queue_beat(b, 1'b0);
        b = make_beat(ucs_pkg::EV_SETUP);
        b.setup_ok = 1'b1;
        b.request_error = 1'b1;
        queue_beat(b, 1'b0);
        // empty reply, full buffer with owed zero-length packet, reply cut to wLength
        queue_read(0, 8, 1'b0, 0);
        queue_read(REPLY_BYTES, 65535, 1'b0, 0);
        queue_read(511, 100, 1'b0, 0);
        // write at packet size, write without data, too long, wrong sizes
        queue_write(MAX_PACKET, 1'b0, 0);
        queue_write(0, 1'b0, 0);
        queue_write(REPLY_BYTES + 1, 1'b0, 0);
        queue_write(100, 1'b0, 1);
        queue_write(200, 1'b1, 2);

        // Random: mostly well-formed transfers with random content
        while (n_queued < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            drain = ($urandom_range(0, 39) == 0);
            if (pick < 40) begin
                rlen = pick_reply_length();
                tweak = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2)) - 1 : 0;
                queue_read(rlen, pick_read_wlen(rlen), drain, tweak);
            end else if (pick < 78) begin
                queue_write(pick_write_wlen(), drain,
                            ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 2)) : 0);
            end else if (pick < 84) begin
                b = make_beat(ucs_pkg::EV_SETUP);
                if ($urandom_range(0, 1)) b.setup_ok = 1'b0;
                else b.request_error = 1'b1;
                queue_beat(b, drain);
                queue_beat(make_beat(ucs_pkg::t_event'($urandom_range(1, 2))), 1'b0);
            end else if (pick < 89) begin
                queue_beat(make_beat(ucs_pkg::EV_BUS_RESET), drain);
                n_resets++;
            end else begin
                queue_beat(make_beat(ucs_pkg::t_event'($urandom_range(0, 3))), drain);
                n_noise++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the backlog, then for every result, then a short tail
        while (event_backlog.size() != 0 || loaded) @(posedge i_clk);
        while (n_results != n_accepted) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (results_due.size() != 0) begin
            $error("%0d expected result beats never arrived", results_due.size());
            n_fail++;
        end

        $display("Covered %0d events: %0d control reads, %0d control writes, %0d bus resets,",
                 n_accepted, n_reads, n_writes, n_resets);
        $display("%0d stray events; %0d results checked, %0d stalls, %0d SET pulses.",
                 n_noise, n_results, n_stalls_seen, n_set_pulses);
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $error("run did not finish in time: %0d accepted, %0d results",
               n_accepted, n_results);
        $display("status: fail");
        $finish;
    end

endmodule
